// File: hdl/vna_pkg.sv
// Shared types and constants of the vertex normal accumulator.
package vna_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int IDX_W = 10;
  localparam int CRD_W = 16;
  localparam int SUM_W = 48;
  localparam int FACE_W = 36;
  localparam int SQ_W = 96;
  localparam int ROOT_W = 130;
  localparam int RES_BITS = 15;
  localparam int CNT_W = 6;
  localparam int SQ_LAST = 47;
  localparam int MUL_LAST = 5;
  localparam int RES_TOP = 14;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TRI = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLR,
    OP_LOAD,
    OP_TRD,
    OP_TGET,
    OP_MUL,
    OP_ACC,
    OP_SRD,
    OP_SWR,
    OP_QRD,
    OP_QGET,
    OP_SQI,
    OP_SQS,
    OP_SQE,
    OP_RTI,
    OP_RTA,
    OP_RTB,
    OP_RTE,
    OP_OUTO,
    OP_OUTF
  } op_t;

  typedef struct packed {
    op_t op;
    logic [CNT_W-1:0] cnt;
    logic [1:0] comp;
    logic [IDX_W-1:0] clr_idx;
  } cmd_t;

  typedef struct packed {
    logic touched;
    logic len2_zero;
  } status_t;

endpackage

// File: hdl/vna_ctrl.sv
// Sequencer that steps the datapath through load, triangle and query work.
module vna_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [1:0] in_action,
  input  vna_pkg::status_t sts,
  output logic busy,
  output vna_pkg::cmd_t cmd
);

  typedef enum logic [20:0] {
    S_CLR  = 21'h000001,
    S_IDLE = 21'h000002,
    S_LOAD = 21'h000004,
    S_TRD  = 21'h000008,
    S_TGET = 21'h000010,
    S_MUL  = 21'h000020,
    S_ACC  = 21'h000040,
    S_SRD  = 21'h000080,
    S_SWR  = 21'h000100,
    S_QRD  = 21'h000200,
    S_QGET = 21'h000400,
    S_SQI  = 21'h000800,
    S_SQS  = 21'h001000,
    S_SQE  = 21'h002000,
    S_CHK  = 21'h004000,
    S_RTI  = 21'h008000,
    S_RTA  = 21'h010000,
    S_RTB  = 21'h020000,
    S_RTE  = 21'h040000,
    S_OUTO = 21'h080000,
    S_OUTF = 21'h100000
  } state_t;

  state_t state_r, state_nxt;
  logic [vna_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [vna_pkg::IDX_W-1:0] clr_r, clr_nxt;
  vna_pkg::op_t op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r <= '0;
      comp_r <= '0;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      comp_r <= comp_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    comp_nxt = comp_r;
    clr_nxt = clr_r;
    op = vna_pkg::OP_NONE;
    case (state_r)
      S_CLR: begin
        op = vna_pkg::OP_CLR;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == vna_pkg::IDX_W'(vna_pkg::VERTEX_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op = vna_pkg::OP_CAPTURE;
          comp_nxt = '0;
          cnt_nxt = '0;
          case (in_action)
            vna_pkg::ACT_LOAD: state_nxt = S_LOAD;
            vna_pkg::ACT_TRI: state_nxt = S_TRD;
            vna_pkg::ACT_QUERY: state_nxt = S_QRD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        op = vna_pkg::OP_LOAD;
        state_nxt = S_IDLE;
      end
      S_TRD: begin
        op = vna_pkg::OP_TRD;
        state_nxt = S_TGET;
      end
      S_TGET: begin
        op = vna_pkg::OP_TGET;
        if (comp_r == 2'd2) begin
          cnt_nxt = '0;
          state_nxt = S_MUL;
        end else begin
          comp_nxt = comp_r + 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_MUL: begin
        op = vna_pkg::OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        op = vna_pkg::OP_ACC;
        if (cnt_r == vna_pkg::CNT_W'(vna_pkg::MUL_LAST)) begin
          comp_nxt = '0;
          state_nxt = S_SRD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_SRD: begin
        op = vna_pkg::OP_SRD;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        op = vna_pkg::OP_SWR;
        if (comp_r == 2'd2) begin
          state_nxt = S_IDLE;
        end else begin
          comp_nxt = comp_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_QRD: begin
        op = vna_pkg::OP_QRD;
        state_nxt = S_QGET;
      end
      S_QGET: begin
        op = vna_pkg::OP_QGET;
        comp_nxt = '0;
        state_nxt = sts.touched ? S_SQI : S_OUTO;
      end
      S_SQI: begin
        op = vna_pkg::OP_SQI;
        cnt_nxt = '0;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        op = vna_pkg::OP_SQS;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == vna_pkg::CNT_W'(vna_pkg::SQ_LAST)) state_nxt = S_SQE;
      end
      S_SQE: begin
        op = vna_pkg::OP_SQE;
        if (comp_r == 2'd2) begin
          state_nxt = S_CHK;
        end else begin
          comp_nxt = comp_r + 1'b1;
          state_nxt = S_SQI;
        end
      end
      S_CHK: begin
        comp_nxt = '0;
        state_nxt = sts.len2_zero ? S_OUTF : S_RTI;
      end
      S_RTI: begin
        op = vna_pkg::OP_RTI;
        cnt_nxt = vna_pkg::CNT_W'(vna_pkg::RES_TOP);
        state_nxt = S_RTA;
      end
      S_RTA: begin
        op = vna_pkg::OP_RTA;
        state_nxt = S_RTB;
      end
      S_RTB: begin
        op = vna_pkg::OP_RTB;
        if (cnt_r == '0) begin
          state_nxt = S_RTE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_RTA;
        end
      end
      S_RTE: begin
        op = vna_pkg::OP_RTE;
        if (comp_r == 2'd2) begin
          state_nxt = S_OUTF;
        end else begin
          comp_nxt = comp_r + 1'b1;
          state_nxt = S_RTI;
        end
      end
      S_OUTO: begin
        op = vna_pkg::OP_OUTO;
        state_nxt = S_IDLE;
      end
      S_OUTF: begin
        op = vna_pkg::OP_OUTF;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign cmd.op = op;
  assign cmd.cnt = cnt_r;
  assign cmd.comp = comp_r;
  assign cmd.clr_idx = clr_r;

endmodule

// File: hdl/vna_dp.sv
// Datapath: vertex memories, cross product, saturating sums, squaring and root search.
module vna_dp (
  input  logic clk,
  input  logic rst_n,
  input  vna_pkg::cmd_t cmd,
  input  logic [9:0] in_first_index,
  input  logic [9:0] in_second_index,
  input  logic [9:0] in_third_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_orig_nx,
  input  logic signed [15:0] in_orig_ny,
  input  logic signed [15:0] in_orig_nz,
  output vna_pkg::status_t sts,
  output logic out_valid,
  output logic [9:0] out_vertex_index,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic out_from_faces
);

  localparam int PW = 3 * vna_pkg::CRD_W;
  localparam int SW = 3 * vna_pkg::SUM_W;

  function automatic logic [vna_pkg::SUM_W-1:0] mag(input logic [vna_pkg::SUM_W-1:0] v);
    return v[vna_pkg::SUM_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [vna_pkg::SUM_W-1:0] sat_add(
      input logic [vna_pkg::SUM_W-1:0] s, input logic [vna_pkg::FACE_W-1:0] f);
    logic [vna_pkg::SUM_W:0] t;
    t = {s[vna_pkg::SUM_W-1], s}
      + {{(vna_pkg::SUM_W - vna_pkg::FACE_W + 1){f[vna_pkg::FACE_W-1]}}, f};
    if (t[vna_pkg::SUM_W] != t[vna_pkg::SUM_W-1])
      return t[vna_pkg::SUM_W] ? {1'b1, {(vna_pkg::SUM_W-1){1'b0}}}
                               : {1'b0, {(vna_pkg::SUM_W-1){1'b1}}};
    return t[vna_pkg::SUM_W-1:0];
  endfunction

  logic [PW-1:0] pos_mem [vna_pkg::VERTEX_COUNT];
  logic [PW-1:0] nrm_mem [vna_pkg::VERTEX_COUNT];
  logic [SW-1:0] sum_mem [vna_pkg::VERTEX_COUNT];
  logic          tch_mem [vna_pkg::VERTEX_COUNT];

  logic [PW-1:0] pos_rd_r, nrm_rd_r;
  logic [SW-1:0] sum_rd_r;
  logic tch_rd_r;

  logic [vna_pkg::IDX_W-1:0] i0_r, i1_r, i2_r, addr, corner;
  logic [PW-1:0] ld_pos_r, ld_nrm_r;

  logic [PW-1:0] p_r [3];
  logic signed [16:0] da [3];
  logic signed [16:0] db [3];
  logic signed [16:0] mx, my;
  logic signed [33:0] prod_r;
  logic [vna_pkg::FACE_W-1:0] f_r [3];

  logic [vna_pkg::SUM_W-1:0] s_r [3];
  logic [PW-1:0] orig_r;
  logic [vna_pkg::SQ_W-1:0] ma_r, acc_r, len2_r;
  logic [vna_pkg::SQ_W-1:0] sq_r [3];
  logic [vna_pkg::SUM_W-1:0] mb_r;

  logic signed [vna_pkg::ROOT_W-1:0] lhs_r, ps_r, ls_r, cand_r, rhs, ps_acc;
  logic [vna_pkg::RES_BITS-1:0] rt_r;
  logic [15:0] res_r [3];
  logic ok;

  logic pos_we, tch_we, tch_wd, sum_we;
  logic [SW-1:0] sum_wd;

  always_comb begin
    case (cmd.comp)
      2'd0: corner = i0_r;
      2'd1: corner = i1_r;
      default: corner = i2_r;
    endcase
  end

  always_comb begin
    case (cmd.op)
      vna_pkg::OP_CLR: addr = cmd.clr_idx;
      vna_pkg::OP_TRD, vna_pkg::OP_SRD, vna_pkg::OP_SWR: addr = corner;
      default: addr = i0_r;
    endcase
  end

  always_comb begin
    pos_we = 1'b0;
    sum_we = 1'b0;
    tch_we = 1'b0;
    tch_wd = 1'b0;
    sum_wd = '0;
    case (cmd.op)
      vna_pkg::OP_CLR: tch_we = 1'b1;
      vna_pkg::OP_LOAD: begin
        pos_we = 1'b1;
        sum_we = 1'b1;
        tch_we = 1'b1;
      end
      vna_pkg::OP_SWR: begin
        sum_we = 1'b1;
        tch_we = 1'b1;
        tch_wd = 1'b1;
        sum_wd = {sat_add(sum_rd_r[3*vna_pkg::SUM_W-1:2*vna_pkg::SUM_W], f_r[2]),
                  sat_add(sum_rd_r[2*vna_pkg::SUM_W-1:vna_pkg::SUM_W], f_r[1]),
                  sat_add(sum_rd_r[vna_pkg::SUM_W-1:0], f_r[0])};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[addr] <= ld_pos_r;
      nrm_mem[addr] <= ld_nrm_r;
    end
    if (sum_we) sum_mem[addr] <= sum_wd;
    if (tch_we) tch_mem[addr] <= tch_wd;
    pos_rd_r <= pos_mem[addr];
    nrm_rd_r <= nrm_mem[addr];
    sum_rd_r <= sum_mem[addr];
    tch_rd_r <= tch_mem[addr];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      da[k] = {p_r[1][16*k+15], p_r[1][16*k +: 16]} - {p_r[0][16*k+15], p_r[0][16*k +: 16]};
      db[k] = {p_r[2][16*k+15], p_r[2][16*k +: 16]} - {p_r[0][16*k+15], p_r[0][16*k +: 16]};
    end
    case (cmd.cnt[2:0])
      3'd0: begin mx = da[1]; my = db[2]; end
      3'd1: begin mx = da[2]; my = db[1]; end
      3'd2: begin mx = da[2]; my = db[0]; end
      3'd3: begin mx = da[0]; my = db[2]; end
      3'd4: begin mx = da[0]; my = db[1]; end
      default: begin mx = da[1]; my = db[0]; end
    endcase
  end

  assign rhs = $signed({4'd0, sq_r[cmd.comp], 30'd0});
  assign ok = (cand_r <= rhs);
  assign ps_acc = ok ? (ps_r + (ls_r <<< 1)) : ps_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      vna_pkg::OP_CAPTURE: begin
        i0_r <= in_first_index;
        i1_r <= in_second_index;
        i2_r <= in_third_index;
        ld_pos_r <= {in_pos_z, in_pos_y, in_pos_x};
        ld_nrm_r <= {in_orig_nz, in_orig_ny, in_orig_nx};
      end
      vna_pkg::OP_TGET: p_r[cmd.comp] <= pos_rd_r;
      vna_pkg::OP_MUL: prod_r <= mx * my;
      vna_pkg::OP_ACC: begin
        if (cmd.cnt[0])
          f_r[cmd.cnt[2:1]] <= f_r[cmd.cnt[2:1]] - vna_pkg::FACE_W'(prod_r);
        else
          f_r[cmd.cnt[2:1]] <= vna_pkg::FACE_W'(prod_r);
      end
      vna_pkg::OP_QGET: begin
        for (int k = 0; k < 3; k++) begin
          s_r[k] <= sum_rd_r[vna_pkg::SUM_W*k +: vna_pkg::SUM_W];
          res_r[k] <= '0;
        end
        orig_r <= nrm_rd_r;
        len2_r <= '0;
      end
      vna_pkg::OP_SQI: begin
        ma_r <= {{(vna_pkg::SQ_W - vna_pkg::SUM_W){1'b0}}, mag(s_r[cmd.comp])};
        mb_r <= mag(s_r[cmd.comp]);
        acc_r <= '0;
      end
      vna_pkg::OP_SQS: begin
        if (mb_r[0]) acc_r <= acc_r + ma_r;
        ma_r <= ma_r << 1;
        mb_r <= mb_r >> 1;
      end
      vna_pkg::OP_SQE: begin
        sq_r[cmd.comp] <= acc_r;
        len2_r <= len2_r + acc_r;
      end
      vna_pkg::OP_RTI: begin
        lhs_r <= $signed({34'd0, len2_r});
        ps_r <= -$signed({18'd0, len2_r, 16'd0});
        ls_r <= $signed({4'd0, len2_r, 30'd0});
        rt_r <= '0;
      end
      vna_pkg::OP_RTA: cand_r <= lhs_r + ps_r + ls_r;
      vna_pkg::OP_RTB: begin
        if (ok) begin
          lhs_r <= cand_r;
          rt_r[cmd.cnt[3:0]] <= 1'b1;
        end
        ps_r <= ps_acc >>> 1;
        ls_r <= ls_r >>> 2;
      end
      vna_pkg::OP_RTE:
        res_r[cmd.comp] <= s_r[cmd.comp][vna_pkg::SUM_W-1] ? (~{1'b0, rt_r} + 1'b1)
                                                           : {1'b0, rt_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (cmd.op == vna_pkg::OP_OUTO) || (cmd.op == vna_pkg::OP_OUTF);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == vna_pkg::OP_OUTO) begin
      out_vertex_index <= i0_r;
      out_normal_x <= orig_r[15:0];
      out_normal_y <= orig_r[31:16];
      out_normal_z <= orig_r[47:32];
      out_from_faces <= 1'b0;
    end else if (cmd.op == vna_pkg::OP_OUTF) begin
      out_vertex_index <= i0_r;
      out_normal_x <= res_r[0];
      out_normal_y <= res_r[1];
      out_normal_z <= res_r[2];
      out_from_faces <= 1'b1;
    end
  end

  assign sts.touched = tch_rd_r;
  assign sts.len2_zero = (len2_r == '0);

endmodule

// File: hdl/vertex_normal_accumulator_core.sv
// Top level of the area-weighted vertex normal accumulator.
// Commands are taken when start is high and busy is low; busy is also high
// after reset while the touched flags are cleared. A triangle does three
// position reads, six products on one 17x17 multiplier and three sum
// read-modify-writes. A query of a touched vertex squares each component
// bit-serially (48 shift-add steps) and, unless its sum is zero, then settles
// each result bit by a trial of the exact rounding test (a candidate step,
// then a compare-and-update step), 15 bits per component. Results appear on
// out_* for exactly one cycle with out_valid and cannot be held off.
module vertex_normal_accumulator_core (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_action,
  input  logic [9:0] in_first_index,
  input  logic [9:0] in_second_index,
  input  logic [9:0] in_third_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_orig_nx,
  input  logic signed [15:0] in_orig_ny,
  input  logic signed [15:0] in_orig_nz,
  output logic out_valid,
  output logic [9:0] out_vertex_index,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic out_from_faces
);

  vna_pkg::cmd_t cmd;
  vna_pkg::status_t sts;

  vna_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_action(in_action),
    .sts(sts),
    .busy(busy),
    .cmd(cmd)
  );

  vna_dp u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .in_first_index(in_first_index),
    .in_second_index(in_second_index),
    .in_third_index(in_third_index),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .in_orig_nx(in_orig_nx),
    .in_orig_ny(in_orig_ny),
    .in_orig_nz(in_orig_nz),
    .sts(sts),
    .out_valid(out_valid),
    .out_vertex_index(out_vertex_index),
    .out_normal_x(out_normal_x),
    .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z),
    .out_from_faces(out_from_faces)
  );

endmodule
